>>> rtl/fr_pkg.sv
// Shared types and constants for the fraction reducer.
// Used by fr_ctrl, fr_datapath and fraction_reduce; depends on nothing.
package fr_pkg;

  // default operand width
  localparam int WIDTH_DEF = 32;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIV_NUM,
    S_DIV_DEN,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;       // capture request, take magnitudes and signs
    logic gcd_step;      // one binary GCD step
    logic div_init_num;  // latch divisor, start numerator division
    logic div_init_den;  // start denominator division
    logic div_step;      // one restoring division bit
    logic cap_num;       // store numerator quotient
    logic cap_den;       // store denominator quotient
    logic load_out;      // fill output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic den_zero;      // latched denominator was zero
    logic gcd_done;      // one GCD operand reached zero
    logic div_last;      // current division step is the final bit
  } status_t;

endpackage

>>> rtl/fr_ctrl.sv
// Controller FSM of the fraction reducer: sequences GCD, two divisions, output.
// Depends on fr_pkg (state_t, cmd_t, status_t).
module fr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  fr_pkg::status_t status,
  output fr_pkg::cmd_t    cmd
);

  fr_pkg::state_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;

  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fr_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = fr_pkg::S_GCD;
      end
      fr_pkg::S_GCD: begin
        if (status.den_zero) state_nxt = fr_pkg::S_DONE;
        else if (status.gcd_done) state_nxt = fr_pkg::S_DIV_NUM;
      end
      fr_pkg::S_DIV_NUM: begin
        if (status.div_last) state_nxt = fr_pkg::S_DIV_DEN;
      end
      fr_pkg::S_DIV_DEN: begin
        if (status.div_last) state_nxt = fr_pkg::S_DONE;
      end
      fr_pkg::S_DONE: begin
        if (out_free) state_nxt = fr_pkg::S_IDLE;
      end
      default: state_nxt = fr_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      fr_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      fr_pkg::S_GCD: begin
        if (!status.den_zero) begin
          if (status.gcd_done) cmd.div_init_num = 1'b1;
          else cmd.gcd_step = 1'b1;
        end
      end
      fr_pkg::S_DIV_NUM: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.cap_num      = 1'b1;
          cmd.div_init_den = 1'b1;
        end
      end
      fr_pkg::S_DIV_DEN: begin
        cmd.div_step = 1'b1;
        cmd.cap_den  = status.div_last;
      end
      fr_pkg::S_DONE: begin
        cmd.load_out = out_free;
      end
      default: cmd = '0;
    endcase
  end

  // output valid flag: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/fr_datapath.sv
// Datapath of the fraction reducer: magnitudes, binary GCD, shared restoring
// divider and output register. Depends on fr_pkg (cmd_t, status_t).
module fr_datapath #(
  parameter int WIDTH = fr_pkg::WIDTH_DEF
) (
  input  logic                              clk,
  input  logic [((2*WIDTH+7)/8)*8-1:0]      in_tdata,
  output logic [((2*WIDTH-1+7)/8)*8-1:0]    out_tdata,
  output logic                              out_tuser,
  input  fr_pkg::cmd_t                      cmd,
  output fr_pkg::status_t                   status
);

  localparam int KW     = $clog2(WIDTH);
  localparam int OUT_TW = ((2*WIDTH-1+7)/8)*8;

  logic [WIDTH-1:0] num_in, den_in, num_mag, den_mag;

  logic [WIDTH-1:0] a_r, b_r, num_mag_r, den_mag_r, g_r, q_r, rem_r;
  logic [WIDTH-1:0] qnum_r, qden_r, out_num_r;
  logic [WIDTH-2:0] out_den_r;
  logic [KW-1:0]    k_r, cnt_r;
  logic             num_neg_r, den_neg_r, den_zero_r, out_err_r;

  // split request and take magnitudes
  assign num_in  = in_tdata[WIDTH-1:0];
  assign den_in  = in_tdata[2*WIDTH-1:WIDTH];
  assign num_mag = num_in[WIDTH-1] ? (~num_in + 1'b1) : num_in;
  assign den_mag = den_in[WIDTH-1] ? (~den_in + 1'b1) : den_in;

  // binary GCD step terms
  logic [WIDTH:0]   diff_ab, diff_ba;
  logic             a_ge_b;
  logic [WIDTH-1:0] g_calc;

  assign diff_ab = {1'b0, a_r} - {1'b0, b_r};
  assign diff_ba = {1'b0, b_r} - {1'b0, a_r};
  assign a_ge_b  = !diff_ab[WIDTH];
  assign g_calc  = (a_r | b_r) << k_r;

  // restoring division step terms
  logic [WIDTH:0]   div_sh;
  logic [WIDTH+1:0] trial;
  logic             div_ge;
  logic [WIDTH-1:0] rem_step, q_step;

  assign div_sh   = {rem_r, q_r[WIDTH-1]};
  assign trial    = {1'b0, div_sh} - {2'b00, g_r};
  assign div_ge   = !trial[WIDTH+1];
  assign rem_step = div_ge ? trial[WIDTH-1:0] : div_sh[WIDTH-1:0];
  assign q_step   = {q_r[WIDTH-2:0], div_ge};

  // result sign and final values
  logic             negative;
  logic [WIDTH-1:0] num_signed;

  assign negative   = (num_neg_r ^ den_neg_r) && (qnum_r != '0);
  assign num_signed = negative ? (~qnum_r + 1'b1) : qnum_r;

  // input capture and GCD registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_r        <= num_mag;
      b_r        <= den_mag;
      k_r        <= '0;
      num_mag_r  <= num_mag;
      den_mag_r  <= den_mag;
      num_neg_r  <= num_in[WIDTH-1];
      den_neg_r  <= den_in[WIDTH-1];
      den_zero_r <= (den_in == '0);
    end else if (cmd.gcd_step) begin
      if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_ge_b) begin
        a_r <= {1'b0, diff_ab[WIDTH-1:1]};
      end else begin
        b_r <= {1'b0, diff_ba[WIDTH-1:1]};
      end
    end
  end

  // divider registers
  always_ff @(posedge clk) begin
    if (cmd.div_init_num) g_r <= g_calc;
    if (cmd.div_init_num || cmd.div_init_den) begin
      q_r   <= cmd.div_init_num ? num_mag_r : den_mag_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      q_r   <= q_step;
      rem_r <= rem_step;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.cap_num) qnum_r <= q_step;
    if (cmd.cap_den) qden_r <= q_step;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_err_r <= den_zero_r;
      out_num_r <= den_zero_r ? '0 : num_signed;
      out_den_r <= den_zero_r ? '0 : qden_r[WIDTH-2:0];
    end
  end

  assign out_tdata = OUT_TW'({out_den_r, out_num_r});
  assign out_tuser = out_err_r;

  assign status.den_zero = den_zero_r;
  assign status.gcd_done = (a_r == '0) || (b_r == '0);
  assign status.div_last = (cnt_r == KW'(WIDTH-1));

endmodule

>>> rtl/fraction_reduce.sv
// Sequence: capture, binary GCD (one step per cycle, step count set by
// operand bit lengths), numerator then denominator division on one shared
// restoring divider (one quotient bit per cycle), then the output register.
// One request in flight; a zero denominator skips GCD and division.
// Synchronous active-low reset clears controller state and output valid;
// datapath registers hold no reset.
module fraction_reduce #(
  parameter int WIDTH = fr_pkg::WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // fields from bit 0: numerator, denominator
  input  logic [((2*WIDTH+7)/8)*8-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // fields from bit 0: reduced_numerator, reduced_denominator
  output logic [((2*WIDTH-1+7)/8)*8-1:0]    out_tdata,
  // fields from bit 0: zero_denominator
  output logic                              out_tuser
);

  fr_pkg::cmd_t    cmd;
  fr_pkg::status_t status;

  fr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  fr_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cmd       (cmd),
    .status    (status)
  );

  // one request at a time: no second capture right after one
  a_single_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while one is in flight");

  // error result carries zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("zero denominator result with nonzero data");

  // zero numerator reduces to 0/1
  a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser && (out_tdata[WIDTH-1:0] == '0))
      |-> (out_tdata[2*WIDTH-2:WIDTH] == (WIDTH-1)'(1)))
    else $error("zero numerator not reduced to 0/1");

  // GCD, division and output commands never overlap capture
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |-> !(cmd.gcd_step || cmd.div_step || cmd.load_out))
    else $error("capture overlaps another datapath command");

endmodule
